@@ src/dvrt_pkg.sv @@
// shared types and constants for the distance-vector route table
// no dependencies
package dvrt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH     = 32;
  localparam int unsigned DEF_INFINITY_METRIC = 16;
  localparam logic [15:0] ROUTE_TIMEOUT_RST   = 16'd180;
  localparam logic [15:0] GARBAGE_TIMEOUT_RST = 16'd120;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [2:0] ST_UPDATED    = 3'd0;
  localparam logic [2:0] ST_INSERTED   = 3'd1;
  localparam logic [2:0] ST_BAD_METRIC = 3'd2;
  localparam logic [2:0] ST_UNREACH    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_ANSWERED   = 3'd5;
  localparam logic [2:0] ST_TICK_DONE  = 3'd6;

  localparam logic CFG_ROUTE_TIMEOUT   = 1'b0;
  localparam logic CFG_GARBAGE_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_RESULT
  } dvrt_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction, clear scan
    logic scan_step;  // process current slot, advance
    logic commit;     // apply update decision
    logic out_load;   // present result
  } dvrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic valid_func;
  } dvrt_sts_t;

endpackage

@@ src/dvrt_datapath.sv @@
// slot memories, slot scan and result register of the route table
// depends on dvrt_pkg
module dvrt_datapath import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int unsigned INFINITY_METRIC = DEF_INFINITY_METRIC
) (
  input  logic        clk,
  input  logic        rst,
  input  dvrt_cmd_t   cmd,
  output dvrt_sts_t   sts,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_dest,
  input  logic [31:0] in_adv,
  input  logic [31:0] in_peer,
  input  logic        in_last,
  input  logic [15:0] route_timeout,
  input  logic [15:0] garbage_timeout,
  output logic [2:0]  out_status,
  output logic [4:0]  out_metric,
  output logic [5:0]  out_removed,
  output logic        out_last
);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = $clog2(INFINITY_METRIC + 1);
  localparam logic [MW-1:0] INF = MW'(INFINITY_METRIC);

  // per-slot flags in flip-flops
  logic [TABLE_DEPTH-1:0] slot_valid, slot_collecting;
  // payload memories, read at the scan index only
  logic [31:0]   mem_dest    [TABLE_DEPTH];
  logic [31:0]   mem_hop     [TABLE_DEPTH];
  logic [MW-1:0] mem_metric  [TABLE_DEPTH];
  logic [31:0]   mem_refresh [TABLE_DEPTH];
  logic [31:0]   mem_garbage [TABLE_DEPTH];

  logic [31:0] seconds_now;
  logic [1:0]  func;
  logic [31:0] dest, peer, adv;
  logic        last;
  logic [IW-1:0] idx;
  logic [CW-1:0] removed;
  logic          hit_found, free_found;
  logic [IW-1:0] hit_idx, free_idx;
  logic [MW-1:0] q_metric;
  logic          q_found;

  // registered read of current slot
  logic [31:0]   rd_dest, rd_hop, rd_refresh, rd_garbage;
  logic [MW-1:0] rd_metric;
  logic [IW-1:0] rd_idx;
  logic          rd_ok;

  logic          adv_bad;
  logic [MW-1:0] new_metric;
  assign adv_bad    = adv > 32'(INFINITY_METRIC);
  assign new_metric = (adv[MW-1:0] >= INF) ? INF : adv[MW-1:0] + MW'(1);

  assign sts.scan_last  = (idx == IW'(TABLE_DEPTH - 1));
  assign sts.valid_func = (func == FUNC_UPDATE) || (func == FUNC_TICK) || (func == FUNC_QUERY);

  always_ff @(posedge clk) begin
    rd_dest    <= mem_dest[idx];
    rd_hop     <= mem_hop[idx];
    rd_metric  <= mem_metric[idx];
    rd_refresh <= mem_refresh[idx];
    rd_garbage <= mem_garbage[idx];
    rd_idx     <= idx;
  end

  logic        rv, rc;
  logic [31:0] age, gage, gtime;
  logic        expired;
  assign rv      = slot_valid[rd_idx];
  assign rc      = slot_collecting[rd_idx];
  assign age     = seconds_now - rd_refresh;
  assign expired = age > {16'd0, route_timeout};
  assign gtime   = rc ? rd_garbage : seconds_now;
  assign gage    = seconds_now - gtime;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      slot_collecting <= '0;
      seconds_now     <= '0;
      rd_ok           <= 1'b0;
    end else begin
      // each slot read is evaluated exactly once
      rd_ok <= cmd.scan_step;
      if (cmd.load) begin
        func <= in_func; dest <= in_dest; adv <= in_adv;
        peer <= in_peer; last <= in_last;
        idx <= '0; removed <= '0;
        hit_found <= 1'b0; free_found <= 1'b0; q_found <= 1'b0;
        if (in_func == FUNC_TICK) seconds_now <= seconds_now + 32'd1;
      end
      if (cmd.scan_step && !sts.scan_last) idx <= idx + IW'(1);
      // evaluate the registered slot in the cycle after its index was presented
      if (rd_ok) begin
        case (func)
          FUNC_UPDATE: begin
            if (rv && rd_dest == dest && !hit_found) begin
              hit_found <= 1'b1; hit_idx <= rd_idx;
            end
            if (!rv && !free_found) begin
              free_found <= 1'b1; free_idx <= rd_idx;
            end
          end
          FUNC_QUERY: begin
            if (rv && rd_dest == dest && rd_hop != peer && !q_found) begin
              q_found <= 1'b1; q_metric <= rd_metric;
            end
          end
          FUNC_TICK: begin
            if (rv && expired) begin
              mem_metric[rd_idx] <= INF;
              if (!rc) mem_garbage[rd_idx] <= seconds_now;
              if (gage > {16'd0, garbage_timeout}) begin
                slot_valid[rd_idx]      <= 1'b0;
                slot_collecting[rd_idx] <= 1'b0;
                removed <= removed + CW'(1);
              end else begin
                slot_collecting[rd_idx] <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.commit && func == FUNC_UPDATE && !adv_bad) begin
        if (hit_found || (new_metric != INF && free_found)) begin
          mem_dest[hit_found ? hit_idx : free_idx]    <= dest;
          mem_hop[hit_found ? hit_idx : free_idx]     <= peer;
          mem_metric[hit_found ? hit_idx : free_idx]  <= new_metric;
          mem_refresh[hit_found ? hit_idx : free_idx] <= seconds_now;
          slot_collecting[hit_found ? hit_idx : free_idx] <= 1'b0;
          slot_valid[hit_found ? hit_idx : free_idx]      <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last <= last;
      case (func)
        FUNC_UPDATE: begin
          out_removed <= '0;
          if (adv_bad) begin
            out_status <= ST_BAD_METRIC;
            out_metric <= '0;
          end else begin
            out_metric <= 5'(new_metric);
            if (hit_found) out_status <= ST_UPDATED;
            else if (new_metric == INF) out_status <= ST_UNREACH;
            else if (free_found) out_status <= ST_INSERTED;
            else out_status <= ST_FULL;
          end
        end
        FUNC_TICK: begin
          out_status  <= ST_TICK_DONE;
          out_metric  <= '0;
          out_removed <= 6'(removed);
        end
        default: begin
          out_status  <= ST_ANSWERED;
          out_metric  <= 5'(q_found ? q_metric : INF);
          out_removed <= '0;
        end
      endcase
    end
  end
endmodule

@@ src/dvrt_ctrl.sv @@
// sequencer for one transaction: scan, commit, result handshake
// depends on dvrt_pkg
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dvrt_sts_t sts,
  output dvrt_cmd_t cmd
);
  dvrt_state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      state <= state_next; out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.valid_func) state_next = S_IDLE;
        else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        // last slot read lands this cycle
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // wait here while the previous result is still on the output
        if (!out_valid || out_ready) begin
          cmd.commit     = 1'b1;
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ src/distance_vector_route_table_unit.sv @@
// top level of the distance-vector route table
// depends on dvrt_pkg, dvrt_ctrl, dvrt_datapath
//
// every transaction (update, one-second tick or query) walks all TABLE_DEPTH
// slots once through one registered read port before its result is
// registered; the next input is taken the cycle after, so no transaction is
// accepted before the last one's result is registered. the input is also
// taken while a result still waits on the output; that transaction then
// holds in its result state, before its commit, until the waiting result
// leaves. func value 3 is dropped without a result. the user must see that
// timeouts are written on the cfg port only while idle; it is not enforced.
module distance_vector_route_table_unit import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int unsigned INFINITY_METRIC = DEF_INFINITY_METRIC
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // func, dest_addr, adv_metric, peer_addr, zero pad
  input  logic         s_tlast,  // last_in_packet
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,  // status, out_metric, removed_count, zero pad
  output logic         m_tlast,  // last_out
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);
  dvrt_cmd_t   cmd;
  dvrt_sts_t   sts;
  logic [15:0] route_timeout, garbage_timeout;
  logic [2:0]  status;
  logic [4:0]  metric;
  logic [5:0]  removed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      route_timeout   <= ROUTE_TIMEOUT_RST;
      garbage_timeout <= GARBAGE_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROUTE_TIMEOUT) route_timeout <= cfg_wdata;
      else garbage_timeout <= cfg_wdata;
    end
  end

  dvrt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .sts, .cmd
  );

  dvrt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH), .INFINITY_METRIC(INFINITY_METRIC)
  ) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_func(s_tdata[1:0]), .in_dest(s_tdata[33:2]), .in_adv(s_tdata[65:34]),
    .in_peer(s_tdata[97:66]), .in_last(s_tlast),
    .route_timeout, .garbage_timeout,
    .out_status(status), .out_metric(metric), .out_removed(removed), .out_last(m_tlast)
  );

  assign m_tdata = {2'b00, removed, metric, status};
endmodule

@@ src/dvrt_checker.sv @@
// port-level checks for the route table
// depends on dvrt_pkg and distance_vector_route_table_unit
module dvrt_checker import dvrt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted during scan");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7) else $error("bad status");
  a_removed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_TICK_DONE |-> m_tdata[13:8] == 6'd0)
    else $error("stray count");
endmodule

bind distance_vector_route_table_unit dvrt_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
